// ----- design/pdp_pkg.sv -----
// Package for the polyline Douglas-Peucker core: sizes, widths, shared types.
// No dependencies.
package pdp_pkg;
  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 24;
  localparam int IDX_BITS   = $clog2(MAX_POINTS);
  localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
  localparam int TOL_BITS   = 24;
  localparam int MINV_BITS  = 7;
  localparam int CFG_BITS   = 24;
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_VERTICES = 1'd1;
  // difference of two coordinates
  localparam int DIFF_BITS  = COORD_BITS + 1;
  // squares and cross products
  localparam int PROD_BITS  = 2 * DIFF_BITS + 1;
  // product of two metrics
  localparam int WIDE_BITS  = 2 * PROD_BITS;
  localparam int MUL_BITS   = 32;
  localparam int ACC_BITS   = WIDE_BITS + 2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] kept_x;
    logic signed [COORD_BITS-1:0] kept_y;
    logic [CNT_BITS-1:0]          kept_count;
    logic                         contour_saved;
    logic                         last_of_run;
  } out_item_t;

  // request to the shared multiplier unit
  typedef struct packed {
    logic                   start;
    logic [WIDE_BITS-1:0]   a;
    logic [WIDE_BITS-1:0]   b;
  } mul_req_t;

  typedef struct packed {
    logic                   busy;
    logic                   done;
    logic [WIDE_BITS-1:0]   p;
  } mul_rsp_t;
endpackage

// ----- design/pdp_if.sv -----
// Valid/ready channel interfaces carrying input points (in_item_t) and output vertices (out_item_t).
// Depends on pdp_pkg for payload types.
interface pdp_in_if (input logic clk);
  import pdp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pdp_out_if (input logic clk);
  import pdp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/pdp_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module pdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- design/pdp_mul.sv -----
// Shared unsigned multiplier: WIDE x WIDE product built from 32x32 partial
// products, one per cycle. Depends on pdp_pkg.
module pdp_mul (
  input  logic              clk,
  input  logic              rst,
  input  pdp_pkg::mul_req_t req,
  output pdp_pkg::mul_rsp_t rsp
);
  import pdp_pkg::*;
  localparam int NLIMB = (WIDE_BITS + MUL_BITS - 1) / MUL_BITS;
  localparam int LB = $clog2(NLIMB) > 0 ? $clog2(NLIMB) : 1;
  localparam int PADW = NLIMB * MUL_BITS;

  logic [PADW-1:0]        a, b;
  logic [LB-1:0]          i, j;
  logic [2*MUL_BITS-1:0]  pp;
  logic [PADW-1:0]        acc;
  logic [PADW-1:0]        pp_sh;
  logic                   busy, done;
  logic                   pp_valid;
  logic [2*LB:0]          shift_limbs;
  logic [LB:0]            i_w, j_w;

  assign i_w = {1'b0, i};
  assign j_w = {1'b0, j};

  // one partial product a[i]*b[j] per cycle, registered
  always_ff @(posedge clk) begin
    pp <= a[i*MUL_BITS +: MUL_BITS] * b[j*MUL_BITS +: MUL_BITS];
    shift_limbs <= (2*LB+1)'(i_w + j_w);
  end

  always_comb begin
    pp_sh = PADW'(pp) << (shift_limbs * MUL_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      pp_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      if (pp_valid) acc <= acc + pp_sh;
      if (req.start && !busy) begin
        a <= PADW'(req.a);
        b <= PADW'(req.b);
        i <= '0;
        j <= '0;
        acc <= '0;
        busy <= 1'b1;
        pp_valid <= 1'b0;
      end else if (busy) begin
        pp_valid <= 1'b1;
        if (32'(j) == NLIMB - 1) begin
          j <= '0;
          if (32'(i) == NLIMB - 1) begin
            busy <= 1'b0;
          end else begin
            i <= i + 1'b1;
          end
        end else begin
          j <= j + 1'b1;
        end
      end else if (pp_valid) begin
        pp_valid <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign rsp.busy = busy || pp_valid;
  assign rsp.done = done;
  assign rsp.p    = acc[WIDE_BITS-1:0];
endmodule

// ----- design/polyline_douglas_peucker_core.sv -----
// Polyline Douglas-Peucker core: loads one point per cycle, then simplifies
// with a span stack and one shared multiplier. After the last point it scans
// the interior points of each span, counts the kept vertices over all
// MAX_POINTS entries, then emits each kept vertex. Not ready until the last
// result is taken. Sync reset: loading, tolerance 0, min_vertices 3.
module polyline_douglas_peucker_core (
  input  logic                            clk,
  input  logic                            rst,
  pdp_in_if.sink                          in_ch,
  pdp_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [pdp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [pdp_pkg::CFG_BITS-1:0]    cfg_data
);
  import pdp_pkg::*;

  typedef enum logic [4:0] {
    S_LOAD, S_START, S_POP, S_RD_AB, S_WT_AB, S_GET_A, S_GET_B, S_RD_I, S_WT_I,
    S_GET_I, S_MUL1, S_MUL2, S_MUL3, S_CMPM, S_T1, S_T2, S_T3, S_T4, S_DECIDE,
    S_DROP, S_TWO, S_CNT, S_EMIT_RD, S_EMIT_WT, S_EMIT
  } state_t;

  state_t state;
  logic [TOL_BITS-1:0]  tolerance;
  logic [MINV_BITS-1:0] min_vertices;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= '0;
      min_vertices <= MINV_BITS'(3);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOLERANCE:    tolerance <= cfg_data[TOL_BITS-1:0];
        REG_MIN_VERTICES: min_vertices <= cfg_data[MINV_BITS-1:0];
        default: ;
      endcase
    end
  end

  // coordinate store
  logic                  st_we;
  logic [IDX_BITS-1:0]   st_waddr, st_raddr;
  logic [2*COORD_BITS-1:0] st_wdata, st_rdata;
  pdp_ram #(.WIDTH(2*COORD_BITS), .DEPTH(MAX_POINTS)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );
  logic signed [COORD_BITS-1:0] rd_x, rd_y;
  assign rd_x = st_rdata[2*COORD_BITS-1:COORD_BITS];
  assign rd_y = st_rdata[COORD_BITS-1:0];

  // span stack
  logic                  sk_we;
  logic [IDX_BITS-1:0]   sk_waddr, sk_raddr;
  logic [2*IDX_BITS-1:0] sk_wdata, sk_rdata;
  pdp_ram #(.WIDTH(2*IDX_BITS), .DEPTH(MAX_POINTS)) u_stack (
    .clk(clk), .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
    .raddr(sk_raddr), .rdata(sk_rdata)
  );

  mul_req_t mreq;
  mul_rsp_t mrsp;
  pdp_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));

  logic [MAX_POINTS-1:0] keep;
  logic [CNT_BITS-1:0]   npts, kept, emitted;
  logic [CNT_BITS-1:0]   depth;
  logic [IDX_BITS-1:0]   lo, hi, idx, best_i;
  logic signed [COORD_BITS-1:0] ax, ay, bx, by;
  logic signed [DIFF_BITS-1:0]  vx, vy, ux, uy;
  logic                  closed, first, push_phase;
  logic [PROD_BITS-1:0]  m, best, p1;
  logic [WIDE_BITS-1:0]  t1, t2;
  logic [TOL_BITS-1:0]   tol_l;
  logic [1:0]            pushes;
  logic [IDX_BITS-1:0]   cnt_i;
  logic signed [COORD_BITS:0] sum_x, sum_y;

  function automatic logic [DIFF_BITS-1:0] mag(input logic signed [DIFF_BITS-1:0] d);
    mag = d[DIFF_BITS-1] ? DIFF_BITS'(-d) : DIFF_BITS'(d);
  endfunction

  assign in_ch.ready = (state == S_LOAD);
  assign out_ch.valid = (state == S_EMIT);

  logic in_fire;
  assign in_fire = in_ch.valid && in_ch.ready;

  // stack top is always being read, so the popped span is ready in S_RD_AB
  assign sk_raddr = IDX_BITS'(depth - 1'b1);

  always_comb begin
    st_we = 1'b0;
    st_waddr = npts[IDX_BITS-1:0];
    st_wdata = {in_ch.data.point_x, in_ch.data.point_y};
    if (state == S_LOAD && in_fire && npts < CNT_BITS'(MAX_POINTS)) st_we = 1'b1;
    if (state == S_TWO && !first) begin
      st_we = 1'b1;
      st_waddr = '0;
      st_wdata = {sum_x[COORD_BITS:1], sum_y[COORD_BITS:1]};
    end
  end

  // shared-unit sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      npts <= '0;
      depth <= '0;
      out_ch.data <= '0;
      sk_we <= 1'b0;
      mreq.start <= 1'b0;
    end else begin
      sk_we <= 1'b0;
      mreq.start <= 1'b0;
      case (state)
        S_LOAD: if (in_fire) begin
          if (npts < CNT_BITS'(MAX_POINTS)) npts <= npts + 1'b1;
          if (in_ch.data.last_point) state <= S_START;
        end
        S_START: begin
          keep <= '1;
          tol_l <= tolerance;
          if (npts == CNT_BITS'(2)) begin
            st_raddr <= '0;
            first <= 1'b1;
            state <= S_RD_AB;
          end else if (npts >= CNT_BITS'(3)) begin
            sk_we <= 1'b1;
            sk_waddr <= '0;
            sk_wdata <= {IDX_BITS'(0), IDX_BITS'(npts - 1'b1)};
            depth <= CNT_BITS'(1);
            state <= S_POP;
          end else begin
            state <= S_CNT;
            cnt_i <= '0;
            kept <= '0;
          end
        end
        S_POP: begin
          if (sk_we) begin
            state <= S_POP;
          end else if (depth == '0) begin
            kept <= '0;
            cnt_i <= '0;
            state <= S_CNT;
          end else begin
            depth <= depth - 1'b1;
            state <= S_RD_AB;
            first <= 1'b0;
          end
        end
        S_RD_AB: begin
          if (npts != CNT_BITS'(2)) begin
            lo <= sk_rdata[2*IDX_BITS-1:IDX_BITS];
            hi <= sk_rdata[IDX_BITS-1:0];
            st_raddr <= sk_rdata[2*IDX_BITS-1:IDX_BITS];
          end
          state <= S_WT_AB;
        end
        S_WT_AB: begin
          if (npts == CNT_BITS'(2)) st_raddr <= IDX_BITS'(1);
          else st_raddr <= hi;
          if (npts != CNT_BITS'(2) && 32'(hi) <= 32'(lo) + 1) state <= S_POP;
          else state <= S_GET_A;
        end
        S_GET_A: begin
          ax <= rd_x;
          ay <= rd_y;
          state <= S_GET_B;
        end
        S_GET_B: begin
          bx <= rd_x;
          by <= rd_y;
          vx <= DIFF_BITS'(rd_x) - DIFF_BITS'(ax);
          vy <= DIFF_BITS'(rd_y) - DIFF_BITS'(ay);
          closed <= (rd_x == ax) && (rd_y == ay);
          if (npts == CNT_BITS'(2)) begin
            ux <= DIFF_BITS'(rd_x) - DIFF_BITS'(ax);
            uy <= DIFF_BITS'(rd_y) - DIFF_BITS'(ay);
            closed <= 1'b1;
            state <= S_MUL1;
          end else begin
            idx <= lo + 1'b1;
            st_raddr <= lo + 1'b1;
            first <= 1'b1;
            state <= S_RD_I;
          end
        end
        S_RD_I: state <= S_WT_I;
        S_WT_I: state <= S_GET_I;
        S_GET_I: begin
          ux <= DIFF_BITS'(rd_x) - DIFF_BITS'(ax);
          uy <= DIFF_BITS'(rd_y) - DIFF_BITS'(ay);
          state <= S_MUL1;
        end
        // first product: ux*ux or |ux|*|vy|
        S_MUL1: if (!mrsp.busy && !mreq.start) begin
          mreq.start <= 1'b1;
          mreq.a <= WIDE_BITS'(mag(ux));
          mreq.b <= closed ? WIDE_BITS'(mag(ux)) : WIDE_BITS'(mag(vy));
          state <= S_MUL2;
        end
        S_MUL2: if (mrsp.done) begin
          p1 <= mrsp.p[PROD_BITS-1:0];
          mreq.start <= 1'b1;
          mreq.a <= WIDE_BITS'(mag(uy));
          mreq.b <= closed ? WIDE_BITS'(mag(uy)) : WIDE_BITS'(mag(vx));
          state <= S_MUL3;
        end
        S_MUL3: if (mrsp.done) begin
          if (closed || ((ux < 0) != (vy < 0)) != ((uy < 0) != (vx < 0)))
            m <= p1 + mrsp.p[PROD_BITS-1:0];
          else if (p1 >= mrsp.p[PROD_BITS-1:0])
            m <= p1 - mrsp.p[PROD_BITS-1:0];
          else
            m <= mrsp.p[PROD_BITS-1:0] - p1;
          state <= S_CMPM;
        end
        S_CMPM: begin
          if (npts == CNT_BITS'(2)) begin
            best <= m;
            state <= S_T1;
          end else begin
            if (first || m > best) begin
              best <= m;
              best_i <= idx;
            end
            first <= 1'b0;
            if (idx + 1'b1 == hi) begin
              state <= S_T1;
            end else begin
              idx <= idx + 1'b1;
              st_raddr <= idx + 1'b1;
              state <= S_RD_I;
            end
          end
        end
        // tol^2
        S_T1: if (!mrsp.busy && !mreq.start) begin
          mreq.start <= 1'b1;
          mreq.a <= WIDE_BITS'(tol_l);
          mreq.b <= WIDE_BITS'(tol_l);
          state <= S_T2;
        end
        S_T2: if (mrsp.done) begin
          t2 <= mrsp.p;
          if (closed) begin
            state <= S_DECIDE;
          end else begin
            ux <= vx;
            uy <= vy;
            mreq.start <= 1'b1;
            mreq.a <= WIDE_BITS'(best);
            mreq.b <= WIDE_BITS'(best);
            state <= S_T3;
          end
        end
        S_T3: if (mrsp.done) begin
          t1 <= mrsp.p;
          mreq.start <= 1'b1;
          mreq.a <= WIDE_BITS'(mag(vx));
          mreq.b <= WIDE_BITS'(mag(vx));
          push_phase <= 1'b0;
          state <= S_T4;
        end
        S_T4: if (mrsp.done) begin
          if (!push_phase) begin
            p1 <= mrsp.p[PROD_BITS-1:0];
            mreq.start <= 1'b1;
            mreq.a <= WIDE_BITS'(mag(vy));
            mreq.b <= WIDE_BITS'(mag(vy));
            push_phase <= 1'b1;
          end else if (!first) begin
            // stage: len2 ready, now tol2*len2
            first <= 1'b1;
            mreq.start <= 1'b1;
            mreq.a <= t2;
            mreq.b <= WIDE_BITS'(p1 + mrsp.p[PROD_BITS-1:0]);
          end else begin
            t2 <= mrsp.p;
            closed <= 1'b0;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          pushes <= 2'd0;
          if (npts == CNT_BITS'(2)) begin
            state <= S_TWO;
            first <= !(WIDE_BITS'(best) <= t2);
            sum_x <= (COORD_BITS+1)'(ax) + (COORD_BITS+1)'(bx);
            sum_y <= (COORD_BITS+1)'(ay) + (COORD_BITS+1)'(by);
          end else if (closed ? (WIDE_BITS'(best) < t2) : (t1 < t2)) begin
            idx <= lo + 1'b1;
            state <= S_DROP;
          end else begin
            state <= S_DROP;
            pushes <= 2'd1;
          end
        end
        S_DROP: begin
          if (pushes == 2'd0) begin
            keep[idx] <= 1'b0;
            if (idx + 1'b1 == hi) state <= S_POP;
            else idx <= idx + 1'b1;
          end else if (pushes == 2'd1) begin
            if (depth < CNT_BITS'(MAX_POINTS)) begin
              sk_we <= 1'b1;
              sk_waddr <= depth[IDX_BITS-1:0];
              sk_wdata <= {best_i, hi};
              depth <= depth + 1'b1;
            end
            pushes <= 2'd2;
          end else begin
            if (depth < CNT_BITS'(MAX_POINTS)) begin
              sk_we <= 1'b1;
              sk_waddr <= depth[IDX_BITS-1:0];
              sk_wdata <= {lo, best_i};
              depth <= depth + 1'b1;
            end
            state <= S_POP;
          end
        end
        S_TWO: begin
          if (!first) keep[1] <= 1'b0;
          kept <= '0;
          cnt_i <= '0;
          state <= S_CNT;
        end
        // count kept vertices
        S_CNT: begin
          if (CNT_BITS'(cnt_i) < npts && keep[cnt_i]) kept <= kept + 1'b1;
          if (32'(cnt_i) == MAX_POINTS - 1) begin
            cnt_i <= '0;
            emitted <= '0;
            first <= 1'b0;
            state <= S_EMIT_RD;
          end else begin
            cnt_i <= cnt_i + 1'b1;
          end
        end
        S_EMIT_RD: begin
          if (kept < CNT_BITS'(min_vertices)) begin
            out_ch.data <= '{kept_x: '0, kept_y: '0, kept_count: kept,
                             contour_saved: 1'b0, last_of_run: 1'b1};
            state <= S_EMIT;
          end else if (keep[cnt_i]) begin
            st_raddr <= cnt_i;
            state <= S_EMIT_WT;
          end else begin
            cnt_i <= cnt_i + 1'b1;
          end
        end
        S_EMIT_WT: begin
          if (!first) begin
            first <= 1'b1;
          end else begin
            first <= 1'b0;
            out_ch.data <= '{kept_x: rd_x, kept_y: rd_y, kept_count: kept,
                             contour_saved: 1'b1,
                             last_of_run: (emitted + 1'b1 == kept)};
            state <= S_EMIT;
          end
        end
        S_EMIT: if (out_ch.ready) begin
          if (out_ch.data.last_of_run) begin
            npts <= '0;
            depth <= '0;
            state <= S_LOAD;
          end else begin
            emitted <= emitted + 1'b1;
            cnt_i <= cnt_i + 1'b1;
            first <= 1'b0;
            state <= S_EMIT_RD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> !in_ch.ready) else $error("ready while busy");
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= CNT_BITS'(MAX_POINTS)) else $error("stack overflow");
  a_npts_bound: assert property (@(posedge clk) disable iff (rst)
    npts <= CNT_BITS'(MAX_POINTS)) else $error("point count overflow");
  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.data.contour_saved) |-> (emitted < kept))
    else $error("emitted more than kept");
`endif
endmodule
